FILE: sv/ctsq_pkg.sv
// Package for the CAN transmit segmenting queue.
// Holds ring geometry constants, operation codes and the payload structs.
// No dependencies.
package ctsq_pkg;

	localparam int BOX_BYTES   = 64;
	localparam int BOX_COUNT   = 8;
	localparam int FRAME_MAX   = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam int OFF_W  = $clog2(BOX_BYTES);
	localparam int REM_W  = $clog2(BOX_BYTES + 1);
	localparam int BOX_W  = $clog2(BOX_COUNT);
	localparam int FREE_W = $clog2(BOX_COUNT + 1);
	localparam int MEM_AW = BOX_W + OFF_W;
	localparam int QP_W   = $clog2(QUEUE_DEPTH);
	localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int NEED_W = 10;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;
	localparam logic KIND_STATUS     = 1'b0;
	localparam logic KIND_FRAME      = 1'b1;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA  = 2'd1,
		OP_DONE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  message_length;
		logic [28:0] frame_id;
		logic [7:0]  frame_kind;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic        result_kind;
		logic        status;
		logic [28:0] out_id;
		logic [7:0]  out_kind;
		logic [3:0]  out_length;
		logic [63:0] out_data;
		logic [3:0]  free_boxes;
	} rsp_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  len;
		logic [28:0] id;
		logic [7:0]  kind;
		logic [7:0]  data;
	} item_t;

endpackage

FILE: sv/ctsq_front.sv
// Front end: accepts requests, decodes the operation and queues work items.
// Depends on ctsq_pkg.
module ctsq_front import ctsq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,
	output logic  item_valid,
	output item_t item,
	input  logic  item_pop
);

	item_t            ent_q [QUEUE_DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QC_W-1:0]  cnt_q;
	op_t              op_dec;
	logic             push;
	logic             pop;

	assign op_dec     = op_t'(req.operation);
	assign req_stall  = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign push       = req_valid && !req_stall && (op_dec != OP_NONE);
	assign item_valid = (cnt_q != '0);
	assign item       = ent_q[rd_ptr_q];
	assign pop        = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{op: op_dec, len: req.message_length, id: req.frame_id,
				kind: req.frame_kind, data: req.data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QC_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointer mismatch");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

FILE: sv/ctsq_back.sv
// Back end: box ring, byte memory, frame gathering and the result register.
// Depends on ctsq_pkg.
module ctsq_back import ctsq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  item_t item,
	output logic  item_pop,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPD    = 3'b010,
		ST_GATHER = 3'b100
	} state_t;

	logic [7:0]        mem [BOX_COUNT * BOX_BYTES];
	logic [7:0]        rdata_q;
	logic [28:0]       box_id_q [BOX_COUNT];
	logic [7:0]        box_kind_q [BOX_COUNT];
	logic [REM_W-1:0]  box_rem_q [BOX_COUNT];

	state_t            st_q;
	logic [BOX_W-1:0]  head_q;
	logic [BOX_W-1:0]  tail_q;
	logic [FREE_W-1:0] free_q;
	logic              running_q;
	logic [OFF_W-1:0]  so_q;
	logic [REM_W-1:0]  wo_q;
	logic [7:0]        bl_q;
	logic              accepting_q;
	logic [28:0]       cur_id_q;
	logic [7:0]        cur_kind_q;
	logic [3:0]        n_q;
	logic [3:0]        iss_q;
	logic [3:0]        cap_q;
	logic              pend_q;
	logic [63:0]       data_q;
	logic              rsp_v_q;
	rsp_t              rsp_q;

	logic              take;
	logic [NEED_W-1:0] need;
	logic              reject;
	logic [REM_W-1:0]  wo_inc;
	logic [7:0]        bl_dec;
	logic              seal;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_wa;
	logic [MEM_AW-1:0] mem_ra;
	logic [REM_W-1:0]  rem_rd;
	logic [3:0]        n_calc;
	logic              fin;
	logic [63:0]       data_nx;
	logic              id_we;
	logic [BOX_W-1:0]  id_wa;
	logic [28:0]       id_wd;
	logic [7:0]        kind_wd;
	logic              rem_we;
	logic [BOX_W-1:0]  rem_wa;
	logic [REM_W-1:0]  rem_wd;

	assign take     = (st_q == ST_IDLE) && item_valid && !rsp_v_q;
	assign item_pop = take;
	assign need     = NEED_W'((NEED_W'(item.len) + NEED_W'(BOX_BYTES - 1)) / BOX_BYTES);
	assign reject   = (item.len == 8'd0) || accepting_q || (NEED_W'(free_q) < need);
	assign wo_inc   = wo_q + 1'b1;
	assign bl_dec   = bl_q - 8'd1;
	assign seal     = (wo_inc == REM_W'(BOX_BYTES)) || (bl_dec == 8'd0);
	assign mem_we   = take && (item.op == OP_DATA) && accepting_q;
	assign mem_wa   = {head_q, wo_q[OFF_W-1:0]};
	assign mem_ra   = {tail_q, OFF_W'(so_q + OFF_W'(iss_q))};
	assign rem_rd   = box_rem_q[tail_q];
	assign n_calc   = (rem_rd > REM_W'(FRAME_MAX)) ? 4'(FRAME_MAX) : 4'(rem_rd);
	assign fin      = (st_q == ST_GATHER) && pend_q && (cap_q + 4'd1 == n_q);
	assign rsp_valid = rsp_v_q;
	assign rsp      = rsp_q;

	always_comb begin
		data_nx = data_q;
		data_nx[cap_q[2:0]*8 +: 8] = rdata_q;
	end

	always_comb begin
		id_we   = 1'b0;
		id_wa   = head_q;
		id_wd   = item.id;
		kind_wd = item.kind;
		rem_we  = 1'b0;
		rem_wa  = head_q;
		rem_wd  = wo_inc;
		if (take && item.op == OP_START && !reject) begin
			id_we = 1'b1;
		end else if (mem_we && seal && bl_dec != 8'd0) begin
			id_we   = 1'b1;
			id_wa   = head_q + 1'b1;
			id_wd   = cur_id_q;
			kind_wd = cur_kind_q;
		end
		if (mem_we && seal) begin
			rem_we = 1'b1;
		end else if (fin) begin
			rem_we = 1'b1;
			rem_wa = tail_q;
			rem_wd = rem_rd - REM_W'(n_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= item.data;
		rdata_q <= mem[mem_ra];
		if (id_we) begin
			box_id_q[id_wa]   <= id_wd;
			box_kind_q[id_wa] <= kind_wd;
		end
		if (rem_we) box_rem_q[rem_wa] <= rem_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			free_q      <= FREE_W'(BOX_COUNT);
			running_q   <= 1'b0;
			so_q        <= '0;
			wo_q        <= '0;
			bl_q        <= '0;
			accepting_q <= 1'b0;
			cur_id_q    <= '0;
			cur_kind_q  <= '0;
			n_q         <= '0;
			iss_q       <= '0;
			cap_q       <= '0;
			pend_q      <= 1'b0;
			data_q      <= '0;
			rsp_v_q     <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_v_q && !rsp_stall) rsp_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (take) begin
						case (item.op)
							OP_START: begin
								rsp_v_q <= 1'b1;
								rsp_q   <= '{result_kind: KIND_STATUS,
									status: reject ? STATUS_REJECTED : STATUS_OK,
									out_id: '0, out_kind: '0, out_length: '0,
									out_data: '0, free_boxes: 4'(free_q)};
								if (!reject) begin
									accepting_q <= 1'b1;
									bl_q        <= item.len;
									wo_q        <= '0;
									cur_id_q    <= item.id;
									cur_kind_q  <= item.kind;
								end
							end
							OP_DATA: begin
								if (accepting_q) begin
									wo_q <= seal ? '0 : wo_inc;
									bl_q <= bl_dec;
									if (seal) begin
										head_q <= head_q + 1'b1;
										if (free_q != '0) free_q <= free_q - 1'b1;
									end
									if (bl_dec == 8'd0) begin
										accepting_q <= 1'b0;
										if (!running_q) begin
											running_q <= 1'b1;
											so_q      <= '0;
											st_q      <= ST_UPD;
										end
									end
								end
							end
							OP_DONE: begin
								if (running_q) st_q <= ST_UPD;
							end
							default: ;
						endcase
					end
				end
				ST_UPD: begin
					if (free_q >= FREE_W'(BOX_COUNT)) begin
						running_q <= 1'b0;
						so_q      <= '0;
						st_q      <= ST_IDLE;
					end else if (rem_rd != '0) begin
						n_q    <= n_calc;
						iss_q  <= '0;
						cap_q  <= '0;
						pend_q <= 1'b0;
						data_q <= '0;
						st_q   <= ST_GATHER;
					end else begin
						tail_q <= tail_q + 1'b1;
						so_q   <= '0;
						if (free_q + 1'b1 >= FREE_W'(BOX_COUNT)) begin
							free_q    <= FREE_W'(BOX_COUNT);
							running_q <= 1'b0;
							st_q      <= ST_IDLE;
						end else begin
							free_q <= free_q + 1'b1;
						end
					end
				end
				ST_GATHER: begin
					pend_q <= (iss_q < n_q);
					if (iss_q < n_q) iss_q <= iss_q + 4'd1;
					if (pend_q) begin
						data_q <= data_nx;
						cap_q  <= cap_q + 4'd1;
					end
					if (fin) begin
						rsp_v_q <= 1'b1;
						rsp_q   <= '{result_kind: KIND_FRAME, status: STATUS_OK,
							out_id: box_id_q[tail_q], out_kind: box_kind_q[tail_q],
							out_length: n_q, out_data: data_nx,
							free_boxes: 4'(free_q)};
						so_q    <= OFF_W'(so_q + OFF_W'(n_q));
						pend_q  <= 1'b0;
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_W'(BOX_COUNT))
		else $error("free count above ring size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_GATHER) |-> (running_q && n_q != 4'd0 && iss_q <= n_q))
		else $error("gather without a live frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		accepting_q |-> (bl_q != 8'd0))
		else $error("accepting with no bytes left");

	assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (rsp_v_q && rsp_q.result_kind == KIND_FRAME))
		else $error("finished frame not presented");

endmodule

FILE: sv/can_tx_segmenting_queue_top.sv
// Top level of the CAN transmit segmenting queue: front queue and back end.
// Requests are queued by the front end; the back end takes one data byte per
// cycle while idle with no response pending. A start answers with a status from
// the result register; after the last byte or a done event the frame of n bytes
// (n up to 8) is gathered with one byte memory read per cycle, after an update
// pass per freed box. Reset clears control state only.
// Depends on ctsq_pkg, ctsq_front and ctsq_back.
module can_tx_segmenting_queue_top import ctsq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic  item_valid;
	item_t item;
	logic  item_pop;

	ctsq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	ctsq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule
